// ===== sv/prlm_pkg.sv =====
`timescale 1ns / 1ps
// prlm_pkg: types and fixed constants of the peak and rms level meter
// no dependencies

package prlm_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int CHAN_W       = 3;
  localparam int DECAY_W      = 16;
  localparam int MAX_CHANNELS = 8;
  localparam int ROOT_W       = 24;
  localparam int RAD_W        = 2 * ROOT_W;
  localparam int SREM_W       = ROOT_W + 1;
  localparam int AU_W         = SREM_W + 2;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd6554;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic REG_CHANNEL = 1'b0;
  localparam logic REG_DECAY   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_BGAP,
    ST_BMUL,
    ST_BUPD,
    ST_DONE
  } prlm_state_t;

endpackage

// ===== sv/peak_rms_level_meter.sv =====
`timescale 1ns / 1ps
// peak_rms_level_meter: per-buffer peak and rms level meter with decay ballistics
// depends on prlm_pkg
// sample word without end mark: accepted, then accumulated; clear word: handled on acceptance
// end-marked word: accumulate, then 46 + clog2(MAX_BUFFER+1) divide steps and 24 root
//   steps on the shared subtract/compare unit, then 6 ballistics steps, before the result
//   word loads; divide and root steps are skipped if no sample was kept
// in_tready is low while a word is in work; one word in flight
// synchronous active-low reset clears meters, buffer state and registers

module peak_rms_level_meter
  import prlm_pkg::*;
#(
  parameter int MAX_BUFFER    = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // channel_index[2:0], sample[26:3]
  input  logic                  in_tuser,   // opcode
  input  logic                  in_tlast,   // end_of_buffer
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // peak_level[23:0], rms_level[47:24]
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CNT_W = $clog2(MAX_BUFFER + 1);
  localparam int SUM_W = 2 * (SAMPLE_W - 1) + CNT_W;
  localparam int IT_W  = $clog2(SUM_W);
  localparam int MW    = SAMPLE_W + FRACTION_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_BUFFER);
  localparam logic [MW-1:0]    FULL_SCALE = MW'(1) << (MW - 1);

  prlm_state_t state_r, state_nxt;

  logic [CHAN_W-1:0]   chan_sel_r;
  logic [DECAY_W-1:0]  decay_r;

  logic                take_r;
  logic                last_r;
  logic [SAMPLE_W-1:0] mag_r;
  logic [2*SAMPLE_W-1:0] sq_r;

  logic [SAMPLE_W-1:0] bpeak_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MW-1:0]       pk_meter_r;
  logic [MW-1:0]       rms_meter_r;

  logic [SUM_W-1:0]    div_r;
  logic [CNT_W-1:0]    drem_r;
  logic [RAD_W-1:0]    rad_r;
  logic [SREM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [IT_W-1:0]     step_r;

  logic                sel_r;
  logic [MW-1:0]       mwork_r;
  logic [MW-1:0]       gap_r;
  logic [MW+DECAY_W-1:0] prod_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_pk_r;
  logic [SAMPLE_W-1:0] out_rms_r;

  logic                in_acc;
  logic                out_load;
  logic                cfg_wr;

  logic [CHAN_W-1:0]   in_chan;
  logic [SAMPLE_W-1:0] in_sample;
  logic signed [2*SAMPLE_W-1:0] in_sq;

  logic                keep;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SAMPLE_W-1:0] bpeak_nxt;

  logic [AU_W-1:0]     au_a;
  logic [AU_W-1:0]     au_b;
  logic [AU_W:0]       au_diff;
  logic                au_ge;
  logic [SUM_W-1:0]    div_nxt;

  logic [SAMPLE_W-1:0] tgt;
  logic [MW-1:0]       tgt_m;
  logic [MW-1:0]       cur_m;
  logic [MW-1:0]       max_m;
  logic [MW-1:0]       upd_m;

  assign in_chan   = in_tdata[CHAN_W-1:0];
  assign in_sample = in_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
  assign in_sq     = $signed(in_sample) * $signed(in_sample);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr[2])
      REG_CHANNEL: cfg_prdata = CFG_DATA_W'(chan_sel_r);
      REG_DECAY:   cfg_prdata = CFG_DATA_W'(decay_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // accumulate step
  assign keep      = take_r && (cnt_r < MAX_CNT);
  assign cnt_nxt   = keep ? cnt_r + 1'b1 : cnt_r;
  assign sum_nxt   = keep ? sum_r + SUM_W'(sq_r[2*SAMPLE_W-2:0]) : sum_r;
  assign bpeak_nxt = (keep && (mag_r > bpeak_r)) ? mag_r : bpeak_r;

  // shared subtract/compare unit for divide and root steps
  always_comb begin
    unique case (state_r)
      ST_DIV: begin
        au_a = AU_W'({drem_r, div_r[SUM_W-1]});
        au_b = AU_W'(cnt_r);
      end
      ST_SQRT: begin
        au_a = {srem_r, rad_r[RAD_W-1 -: 2]};
        au_b = AU_W'({root_r, 2'b01});
      end
      default: begin
        au_a = '0;
        au_b = '0;
      end
    endcase
  end
  assign au_diff = {1'b0, au_a} - {1'b0, au_b};
  assign au_ge   = !au_diff[AU_W];
  assign div_nxt = {div_r[SUM_W-2:0], au_ge};

  // ballistics
  assign tgt   = sel_r ? root_r : bpeak_r;
  assign tgt_m = MW'(tgt) << FRACTION_BITS;
  assign cur_m = sel_r ? rms_meter_r : pk_meter_r;
  assign max_m = (tgt_m > cur_m) ? tgt_m : cur_m;
  assign upd_m = mwork_r - prod_r[MW+DECAY_W-1:DECAY_W];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_tuser == OP_SAMPLE) state_nxt = ST_ACC;
      ST_ACC: begin
        if (!last_r) state_nxt = ST_IDLE;
        else if (cnt_nxt != '0) state_nxt = ST_DIV;
        else state_nxt = ST_BGAP;
      end
      ST_DIV:  if (step_r == '0) state_nxt = ST_SQRT;
      ST_SQRT: if (step_r == '0) state_nxt = ST_BGAP;
      ST_BGAP: state_nxt = ST_BMUL;
      ST_BMUL: state_nxt = ST_BUPD;
      ST_BUPD: state_nxt = sel_r ? ST_DONE : ST_BGAP;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_sel_r  <= '0;
      decay_r     <= DECAY_RESET;
      bpeak_r     <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      pk_meter_r  <= '0;
      rms_meter_r <= '0;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_CHANNEL: chan_sel_r <= cfg_pwdata[CHAN_W-1:0];
          REG_DECAY:   decay_r    <= cfg_pwdata[DECAY_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_tuser == OP_CLEAR) begin
            pk_meter_r  <= '0;
            rms_meter_r <= '0;
          end
        end
        ST_ACC: begin
          cnt_r   <= cnt_nxt;
          sum_r   <= sum_nxt;
          bpeak_r <= bpeak_nxt;
          sel_r   <= 1'b0;
        end
        ST_BUPD: begin
          if (sel_r) rms_meter_r <= upd_m;
          else pk_meter_r <= upd_m;
          sel_r <= 1'b1;
        end
        ST_DONE: begin
          if (out_load) begin
            bpeak_r <= '0;
            sum_r   <= '0;
            cnt_r   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        take_r <= (in_chan == chan_sel_r) && (32'(in_chan) < MAX_CHANNELS) &&
                  (32'(chan_sel_r) < MAX_CHANNELS);
        last_r <= in_tlast;
        mag_r  <= in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
        sq_r   <= $unsigned(in_sq);
      end
      ST_ACC: begin
        div_r  <= sum_nxt;
        drem_r <= '0;
        root_r <= '0;
        step_r <= IT_W'(SUM_W - 1);
      end
      ST_DIV: begin
        div_r  <= div_nxt;
        drem_r <= au_ge ? au_diff[CNT_W-1:0] : au_a[CNT_W-1:0];
        if (step_r == '0) begin
          rad_r  <= RAD_W'(div_nxt);
          srem_r <= '0;
          root_r <= '0;
          step_r <= IT_W'(ROOT_W - 1);
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
      ST_SQRT: begin
        srem_r <= au_ge ? au_diff[SREM_W-1:0] : au_a[SREM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], au_ge};
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        step_r <= step_r - 1'b1;
      end
      ST_BGAP: begin
        mwork_r <= max_m;
        gap_r   <= max_m - tgt_m;
      end
      ST_BMUL: prod_r <= gap_r * decay_r;
      ST_DONE: begin
        if (out_load) begin
          out_pk_r  <= pk_meter_r[FRACTION_BITS +: SAMPLE_W];
          out_rms_r <= rms_meter_r[FRACTION_BITS +: SAMPLE_W];
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rms_r, out_pk_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("sample count above buffer limit");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (drem_r < cnt_r))
    else $error("divide remainder not below divisor");

  a_meter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pk_meter_r <= FULL_SCALE) && (rms_meter_r <= FULL_SCALE))
    else $error("meter above full scale");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_CLEAR) |=> (pk_meter_r == '0 && rms_meter_r == '0))
    else $error("clear word did not zero meters");

endmodule

// ===== dv/peak_rms_level_meter_tb.sv =====
`timescale 1ns / 1ps
// peak_rms_level_meter_tb: self-checking bench for the peak and rms level meter
// random stream stimulus with idle gaps, own level predictor, apb register setup
// depends on prlm_pkg and peak_rms_level_meter

module peak_rms_level_meter_tb
  import prlm_pkg::*;
();

  localparam int FRAC_BITS    = 16;
  localparam int BUF_LIMIT    = 4096;
  localparam int SETTLE_CYCLES = 120;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct {
    logic                op;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] smp;
    logic                eob;
  } meter_word_t;

  typedef struct {
    logic [23:0] peak;
    logic [23:0] rms;
  } level_pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;   // channel_index[2:0], sample[26:3]
  logic                  in_tuser = 1'b0; // opcode
  logic                  in_tlast = 1'b0; // end_of_buffer
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [47:0]           out_tdata;       // peak_level[23:0], rms_level[47:24]
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  peak_rms_level_meter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [CHAN_W-1:0]  sel_chan = '0;
  logic [DECAY_W-1:0] decay = DECAY_RESET;
  logic [23:0]        buf_peak = '0;
  logic [63:0]        sq_sum = '0;
  int                 buf_count = 0;
  logic [39:0]        peak_mtr = '0;
  logic [39:0]        rms_mtr = '0;

  meter_word_t pending[$];
  level_pair_t levels_due[$];
  meter_word_t next_word;
  level_pair_t due;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  int   words_in = 0;
  int   clears_in = 0;
  int   levels_seen = 0;
  int   mismatch_count = 0;

  function automatic logic [23:0] floor_root(logic [63:0] v);
    logic [23:0] r;
    logic [23:0] t;
    logic [63:0] tt;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (24'd1 << b);
      tt = 64'(t);
      if (tt * tt <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [39:0] meter_move(logic [39:0] m, logic [39:0] tgt,
                                             logic [DECAY_W-1:0] dec);
    logic [63:0] drop;
    if (tgt > m) m = tgt;
    drop = (64'(m - tgt) * 64'(dec)) >> 16;
    return m - drop[39:0];
  endfunction

  function automatic void absorb_word(logic op, logic [CHAN_W-1:0] ch,
                                      logic [SAMPLE_W-1:0] smp, logic eob);
    logic [23:0] mag;
    logic [39:0] pk_t;
    logic [39:0] rms_t;
    logic [63:0] mean;
    if (op == OP_CLEAR) begin
      peak_mtr = '0;
      rms_mtr = '0;
      clears_in++;
      return;
    end
    if (ch == sel_chan && buf_count < BUF_LIMIT) begin
      mag = smp[23] ? 24'(-smp) : smp;
      if (mag > buf_peak) buf_peak = mag;
      sq_sum += 64'(mag) * 64'(mag);
      buf_count++;
    end
    if (!eob) return;
    if (buf_count == 0) begin
      pk_t = '0;
      rms_t = '0;
    end else begin
      pk_t = {buf_peak, 16'd0};
      mean = sq_sum / 64'(buf_count);
      rms_t = {floor_root(mean), 16'd0};
    end
    peak_mtr = meter_move(peak_mtr, pk_t, decay);
    rms_mtr = meter_move(rms_mtr, rms_t, decay);
    buf_peak = '0;
    sq_sum = '0;
    buf_count = 0;
    levels_due.push_back('{peak: peak_mtr[39:FRAC_BITS], rms: rms_mtr[39:FRAC_BITS]});
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold word until taken
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap--;
    end else if (pending.size() > 0) begin
      next_word = pending.pop_front();
      in_tdata <= {5'd0, next_word.smp, next_word.chan};
      in_tuser <= next_word.op;
      in_tlast <= next_word.eob;
      in_tvalid <= 1'b1;
      if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
      in_gap = in_calm ? 0 : $urandom_range(0, 10);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      out_stall = out_calm ? 0 : $urandom_range(0, 10);
    end
    if (rst_n && out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_tready <= rst_n;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_took <= in_tvalid && in_tready;
    out_took <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      absorb_word(in_tuser, in_tdata[2:0], in_tdata[26:3], in_tlast);
      words_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      levels_seen++;
      if (levels_due.size() == 0) begin
        $error("level word with no expectation: peak %0d rms %0d",
               out_tdata[23:0], out_tdata[47:24]);
        mismatch_count++;
      end else begin
        due = levels_due.pop_front();
        if (out_tdata[23:0] !== due.peak) begin
          $error("peak_level: expected %0d, got %0d", due.peak, out_tdata[23:0]);
          mismatch_count++;
        end
        if (out_tdata[47:24] !== due.rms) begin
          $error("rms_level: expected %0d, got %0d", due.rms, out_tdata[47:24]);
          mismatch_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_CHANNEL) sel_chan = val[CHAN_W-1:0];
    else decay = val[DECAY_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic push_word(input logic op, input logic [CHAN_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] smp, input logic eob);
    pending.push_back('{op: op, chan: ch, smp: smp, eob: eob});
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      4: return 24'($signed($urandom_range(0, 511)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_buffer(input int len);
    logic [CHAN_W-1:0] ch;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        push_word(OP_CLEAR, CHAN_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
      end
      ch = ($urandom_range(0, 4) != 0) ? sel_chan : CHAN_W'($urandom);
      push_word(OP_SAMPLE, ch, pick_sample(), i == len - 1);
    end
  endtask

  task automatic queue_random(input int n);
    int made;
    int len;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 12);
        queue_buffer(len);
        made += len;
      end else begin
        push_word(($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_SAMPLE, CHAN_W'($urandom),
                  pick_sample(), 1'($urandom));
        made++;
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending.size() > 0 || in_tvalid || levels_due.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    push_word(OP_SAMPLE, 3'd1, 24'h7FFFFF, 1'b1);
    push_word(OP_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0);
    push_word(OP_SAMPLE, 3'd0, 24'h800000, 1'b1);
    push_word(OP_SAMPLE, 3'd0, 24'hFFFFFF, 1'b1);
    push_word(OP_SAMPLE, 3'd0, 24'h000000, 1'b1);
    push_word(OP_SAMPLE, 3'd0, 24'h400000, 1'b0);
    push_word(OP_CLEAR, 3'd0, 24'h800000, 1'b1);
    push_word(OP_SAMPLE, 3'd0, 24'h000001, 1'b1);
    push_word(OP_SAMPLE, 3'd0, 24'h200000, 1'b0);
    push_word(OP_CLEAR, 3'd7, 24'h7FFFFF, 1'b0);
    push_word(OP_SAMPLE, 3'd0, 24'hC00000, 1'b1);
    for (int c = 1; c < 8; c++) push_word(OP_SAMPLE, c[2:0], 24'h7FFFFF, c == 7);
    push_word(OP_SAMPLE, 3'd0, 24'h123456, 1'b0);
    push_word(OP_SAMPLE, 3'd0, 24'hEDCBAA, 1'b1);
    settle();

    write_reg(REG_CHANNEL, 32'd3);
    write_reg(REG_DECAY, 32'd65535);
    queue_random(130);
    settle();

    write_reg(REG_CHANNEL, 32'd7);
    write_reg(REG_DECAY, 32'd0);
    queue_random(130);
    settle();

    write_reg(REG_CHANNEL, 32'd0);
    write_reg(REG_DECAY, {16'd0, 16'($urandom)});
    queue_buffer(5);
    settle();

    write_reg(REG_CHANNEL, {29'd0, 3'($urandom)});
    write_reg(REG_DECAY, {16'd0, 16'($urandom)});
    queue_random(270);
    settle();

    $display("run covered %0d input words (%0d clears) and %0d level words", words_in,
             clears_in, levels_seen);
    $display("settings: reset values, channels 0/3/7 and random, decay 0, max and random");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d level words outstanding", levels_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/prlm_pkg.sv
sv/peak_rms_level_meter.sv
dv/peak_rms_level_meter_tb.sv
